// File: rtl/fwcb_pkg.sv
// fwcb_pkg: shared constants and codes for the flash write-combining buffer.
// No dependencies; imported by rtl/flash_write_combining_buffer.sv.
`timescale 1ns / 1ps

package fwcb_pkg;

  // Program unit size in bytes and the byte offset width within a unit.
  localparam int unsigned UNIT_BYTES = 32;
  localparam int unsigned OFF_W      = $clog2(UNIT_BYTES);
  localparam int unsigned CNT_W      = OFF_W + 1;

  // Address, data and length widths of the stream fields.
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned CODE_W = 3;

  // Packed tdata width (addr, data, length), already a whole number of bytes.
  localparam int unsigned TDATA_W = ADDR_W + DATA_W + LEN_W;

  // Request opcodes (slave side tuser).
  typedef enum logic [CODE_W-1:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_ERASE = 3'd2,
    OP_TRIM  = 3'd3,
    OP_SYNC  = 3'd4,
    OP_FILL  = 3'd5
  } op_e;

  // Result kinds (master side tuser).
  typedef enum logic [CODE_W-1:0] {
    K_HIT   = 3'd0,
    K_READ  = 3'd1,
    K_PROG  = 3'd2,
    K_ERASE = 3'd3,
    K_TRIM  = 3'd4,
    K_SYNC  = 3'd5,
    K_ACK   = 3'd6,
    K_REJ   = 3'd7
  } kind_e;

endpackage

// File: rtl/flash_write_combining_buffer.sv
// flash_write_combining_buffer: single-unit write-combining cache in front of flash.
// Depends on rtl/fwcb_pkg.sv.
`timescale 1ns / 1ps

// One request enters on the slave stream (opcode in tuser, address, data and
// length in tdata) and produces one or more result requests on the master
// stream, the final one marked with tlast. A single 32-byte program unit is
// cached in a small byte memory with a valid flag. A byte write to another
// unit flushes the dirty unit first as 32 program bytes; a partial write into
// an empty cache issues a unit read to the device and then takes exactly 32
// fill requests (op 5, offsets 0..31 in order) before the held write lands;
// a write at offset 0 with a whole unit still to come goes straight through
// as program bytes until offset 31, which adds a sync. Read hits are served
// from the cache; erase and trim drop the cache (no write-back) when the
// cached unit start lies in their range. The block takes one request, then
// is busy. A single-result request goes through accept, decode and result; a
// held write completing its fill adds a merge step; a unit flush takes each
// byte through a memory read, then an output load, as all bytes share the
// one read port of the cache memory. The result register lets the next
// request be accepted while the final result still waits for m_axis_tready.
// No clearing pass is needed after reset: the cache memory is only read once
// a unit is valid.
module flash_write_combining_buffer
  import fwcb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [31:0] addr, [39:32] data, [71:40] length
  input  logic [CODE_W-1:0]  s_axis_tuser,   // [2:0] op
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [31:0] out_addr, [39:32] out_data,
                                             // [71:40] out_length
  output logic [CODE_W-1:0]  m_axis_tuser,   // [2:0] kind
  output logic               m_axis_tlast    // last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PEND,
    S_PROG1,
    S_FLUSH_RD,
    S_FLUSH_EM,
    S_FINAL
  } state_e;

  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(UNIT_BYTES - 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;

  // captured request
  logic [CODE_W-1:0]   op_q, op_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [DATA_W-1:0]   data_q, data_d;
  logic [LEN_W-1:0]    len_q, len_d;

  // cache control state
  logic [ADDR_W-1:0]   cached_q, cached_d;
  logic                valid_q, valid_d;
  logic                await_q, await_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [OFF_W-1:0]    pend_off_q, pend_off_d;
  logic [DATA_W-1:0]   pend_byte_q, pend_byte_d;
  logic                pass_q, pass_d;

  // flush sequencer
  logic [ADDR_W-1:0]   fbase_q, fbase_d;
  logic [OFF_W-1:0]    idx_q, idx_d;

  // final result of the current request
  kind_e               fin_kind_q, fin_kind_d;
  logic [ADDR_W-1:0]   fin_addr_q, fin_addr_d;
  logic [DATA_W-1:0]   fin_data_q, fin_data_d;
  logic [LEN_W-1:0]    fin_len_q, fin_len_d;
  logic                fin_mem_q, fin_mem_d;   // data comes from the cache read

  // result register
  logic                m_valid_q, m_valid_d;
  logic [CODE_W-1:0]   m_kind_q, m_kind_d;
  logic [TDATA_W-1:0]  m_data_q, m_data_d;
  logic                m_last_q, m_last_d;

  // cache memory ports
  logic [DATA_W-1:0]   mem_q [UNIT_BYTES];
  logic                mem_we;
  logic [OFF_W-1:0]    mem_wa;
  logic [DATA_W-1:0]   mem_wd;
  logic                mem_re;
  logic [OFF_W-1:0]    mem_ra;
  logic [DATA_W-1:0]   rd_data_q;

  // ---------------------------------------------------------------------------
  // Derived request fields
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] unit;
  logic [OFF_W-1:0]  off;
  logic              same_unit;
  logic              out_free;
  logic [ADDR_W:0]   range_end;
  logic              in_range;
  logic              flush_first;
  logic              valid_after;

  assign unit      = {addr_q[ADDR_W-1:OFF_W], OFF_W'(0)};
  assign off       = addr_q[OFF_W-1:0];
  assign same_unit = (unit == cached_q);
  assign out_free  = !m_valid_q || m_axis_tready;
  // erase/trim range end is inclusive and may carry past 32 bits
  assign range_end = {1'b0, addr_q} + (ADDR_W+1)'(len_q);
  assign in_range  = (cached_q >= addr_q) && ({1'b0, cached_q} <= range_end);
  // a write into another unit writes back a valid cache first
  assign flush_first = valid_q && !same_unit;
  assign valid_after = valid_q && same_unit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    data_d      = data_q;
    len_d       = len_q;
    cached_d    = cached_q;
    valid_d     = valid_q;
    await_d     = await_q;
    fill_d      = fill_q;
    pend_off_d  = pend_off_q;
    pend_byte_d = pend_byte_q;
    pass_d      = pass_q;
    fbase_d     = fbase_q;
    idx_d       = idx_q;
    fin_kind_d  = fin_kind_q;
    fin_addr_d  = fin_addr_q;
    fin_data_d  = fin_data_q;
    fin_len_d   = fin_len_q;
    fin_mem_d   = fin_mem_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_kind_d    = m_kind_q;
    m_data_d    = m_data_q;
    m_last_d    = m_last_q;
    mem_we      = 1'b0;
    mem_wa      = off;
    mem_wd      = data_q;
    mem_re      = 1'b0;
    mem_ra      = off;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tuser;
          addr_d  = s_axis_tdata[ADDR_W-1:0];
          data_d  = s_axis_tdata[ADDR_W +: DATA_W];
          len_d   = s_axis_tdata[ADDR_W+DATA_W +: LEN_W];
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        fin_kind_d = K_REJ;
        fin_addr_d = '0;
        fin_data_d = '0;
        fin_len_d  = '0;
        fin_mem_d  = 1'b0;
        fbase_d    = cached_q;
        idx_d      = '0;
        state_d    = S_FINAL;
        if (await_q) begin
          if (op_q == OP_FILL && addr_q == ADDR_W'(fill_q)) begin
            mem_we = 1'b1;
            mem_wa = fill_q[OFF_W-1:0];
            fill_d = fill_q + 1'b1;
            if (fill_q[OFF_W-1:0] == LAST_OFF) begin
              state_d = S_PEND;
            end else begin
              fin_kind_d = K_ACK;
            end
          end
        end else if (pass_q) begin
          if (op_q == OP_WRITE && same_unit) begin
            if (off == LAST_OFF) begin
              pass_d     = 1'b0;
              fin_kind_d = K_SYNC;
              state_d    = S_PROG1;
            end else begin
              fin_kind_d = K_PROG;
              fin_addr_d = addr_q;
              fin_data_d = data_q;
            end
          end
        end else begin
          unique case (op_q) inside
            OP_READ: begin
              fin_addr_d = addr_q;
              if (valid_q && same_unit) begin
                mem_re     = 1'b1;
                fin_kind_d = K_HIT;
                fin_mem_d  = 1'b1;
              end else begin
                fin_kind_d = K_READ;
                fin_len_d  = LEN_W'(1);
              end
            end
            OP_WRITE: begin
              if (flush_first) begin
                valid_d = 1'b0;
                state_d = S_FLUSH_RD;
              end
              if (off == '0 && len_q >= LEN_W'(UNIT_BYTES)) begin
                // direct unit write: cached copy is dropped
                valid_d    = 1'b0;
                cached_d   = unit;
                pass_d     = 1'b1;
                fin_kind_d = K_PROG;
                fin_addr_d = addr_q;
                fin_data_d = data_q;
              end else if (!valid_after) begin
                cached_d    = unit;
                await_d     = 1'b1;
                fill_d      = '0;
                pend_off_d  = off;
                pend_byte_d = data_q;
                fin_kind_d  = K_READ;
                fin_addr_d  = unit;
                fin_len_d   = LEN_W'(UNIT_BYTES);
              end else begin
                mem_we = 1'b1;
                if (off == LAST_OFF) begin
                  valid_d    = 1'b0;
                  fin_kind_d = K_SYNC;
                  state_d    = S_FLUSH_RD;
                end else begin
                  fin_kind_d = K_ACK;
                end
              end
            end
            OP_ERASE, OP_TRIM: begin
              if (valid_q && in_range) begin
                valid_d = 1'b0;
              end
              fin_kind_d = (op_q == OP_ERASE) ? K_ERASE : K_TRIM;
              fin_addr_d = addr_q;
              fin_len_d  = len_q;
            end
            OP_SYNC: begin
              fin_kind_d = K_SYNC;
              if (valid_q) begin
                valid_d = 1'b0;
                state_d = S_FLUSH_RD;
              end
            end
            default: begin
              fin_kind_d = K_REJ;
            end
          endcase
        end
      end

      // fill complete: merge the held write byte
      S_PEND: begin
        mem_we  = 1'b1;
        mem_wa  = pend_off_q;
        mem_wd  = pend_byte_q;
        await_d = 1'b0;
        fill_d  = '0;
        fbase_d = cached_q;
        idx_d   = '0;
        if (pend_off_q == LAST_OFF) begin
          fin_kind_d = K_SYNC;
          state_d    = S_FLUSH_RD;
        end else begin
          valid_d    = 1'b1;
          fin_kind_d = K_ACK;
          state_d    = S_FINAL;
        end
      end

      // last direct-write byte ahead of its sync
      S_PROG1: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = K_PROG;
          m_data_d  = {LEN_W'(0), data_q, addr_q};
          m_last_d  = 1'b0;
          state_d   = S_FINAL;
        end
      end

      S_FLUSH_RD: begin
        mem_re  = 1'b1;
        mem_ra  = idx_q;
        state_d = S_FLUSH_EM;
      end

      S_FLUSH_EM: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = K_PROG;
          m_data_d  = {LEN_W'(0), rd_data_q, fbase_q[ADDR_W-1:OFF_W], idx_q};
          m_last_d  = 1'b0;
          if (idx_q == LAST_OFF) begin
            state_d = S_FINAL;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_FLUSH_RD;
          end
        end
      end

      S_FINAL: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = fin_kind_q;
          m_data_d  = {fin_len_q, (fin_mem_q ? rd_data_q : fin_data_q), fin_addr_q};
          m_last_d  = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cached_q    <= '0;
      valid_q     <= 1'b0;
      await_q     <= 1'b0;
      fill_q      <= '0;
      pend_off_q  <= '0;
      pend_byte_q <= '0;
      pass_q      <= 1'b0;
      idx_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cached_q    <= cached_d;
      valid_q     <= valid_d;
      await_q     <= await_d;
      fill_q      <= fill_d;
      pend_off_q  <= pend_off_d;
      pend_byte_q <= pend_byte_d;
      pass_q      <= pass_d;
      idx_q       <= idx_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    data_q     <= data_d;
    len_q      <= len_d;
    fbase_q    <= fbase_d;
    fin_kind_q <= fin_kind_d;
    fin_addr_q <= fin_addr_d;
    fin_data_q <= fin_data_d;
    fin_len_q  <= fin_len_d;
    fin_mem_q  <= fin_mem_d;
    m_kind_q   <= m_kind_d;
    m_data_q   <= m_data_d;
    m_last_q   <= m_last_d;
  end

  // ---------------------------------------------------------------------------
  // Cache memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // fill wait and direct write never overlap
  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(await_q && pass_q))
    else $error("fill wait and direct write both active");

  // fill progress only exists while waiting for fill bytes
  a_fill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> await_q)
    else $error("fill count nonzero outside fill wait");

  // when ready for a new request, any pending result is the final one
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && m_valid_q) |-> m_last_q)
    else $error("non-final result pending while idle");

endmodule

// File: dv/flash_write_combining_buffer_tb.sv
// flash_write_combining_buffer_tb: self-checking stream testbench for the
// write-combining buffer. Depends on rtl/fwcb_pkg.sv and the block's RTL.
`timescale 1ns / 1ps

module flash_write_combining_buffer_tb;
  import fwcb_pkg::*;

  // Opcodes outside the defined set; the block must reject them.
  localparam logic [CODE_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [CODE_W-1:0] OP_SPARE7 = 3'd7;

  // Idle/stall percentages per traffic phase: receiver-heavy stalls,
  // sender-heavy gaps, then back-to-back.
  localparam int SEND_IDLE_PCT [3] = '{11, 85, 0};
  localparam int RECV_STALL_PCT[3] = '{85, 11, 0};
  localparam int RAND_ACCESSES    = 85;
  localparam int TAIL_CYCLES      = 100;

  typedef struct packed {
    logic [CODE_W-1:0] op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              drain;   // hold off until every owed request has come
    logic [1:0]        phase;
  } access_t;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } flash_req_t;

  typedef struct packed {
    logic [UNIT_BYTES-1:0][DATA_W-1:0] bytes;
    logic [ADDR_W-1:0]                 unit_base;
    logic                              valid;
    logic                              awaiting_fill;
    logic [CNT_W-1:0]                  fill_cnt;
    logic [OFF_W-1:0]                  held_off;
    logic [DATA_W-1:0]                 held_byte;
    logic                              direct;
  } unit_cache_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic [CODE_W-1:0]  s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [CODE_W-1:0]  m_axis_tuser;
  logic               m_axis_tlast;

  access_t     access_plan[$];
  flash_req_t  owed_reqs[$];
  unit_cache_t shadow_buf = '0;   // tracks accepted requests
  unit_cache_t plan_buf   = '0;   // tracks planned requests, steers stimulus
  access_t     cur_access = '0;
  logic        holding = 1'b0;
  logic [1:0]  drive_phase = 2'd0;
  logic        drain_next = 1'b0;
  int          planned_live = 0;
  int          errors = 0;

  flash_write_combining_buffer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------
  // Buffer behavior
  // ---------------------------------------------------------------------
  function automatic void add_req(ref flash_req_t res[$], input kind_e k,
                                  input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                                  input logic [LEN_W-1:0] l);
    res.push_back('{k, a, d, l, 1'b0});
  endfunction

  function automatic void flush_unit(ref unit_cache_t st, ref flash_req_t res[$]);
    if (st.valid) begin
      for (int i = 0; i < UNIT_BYTES; i++)
        add_req(res, K_PROG, st.unit_base + ADDR_W'(i), st.bytes[i], '0);
      st.valid = 1'b0;
    end
  endfunction

  function automatic void commit_unit(ref unit_cache_t st, ref flash_req_t res[$]);
    flush_unit(st, res);
    add_req(res, K_SYNC, '0, '0, '0);
  endfunction

  // Applies one access to the cache state and lists the device-side requests it causes.
  function automatic void combine_access(ref unit_cache_t st, input access_t a,
                                         ref flash_req_t res[$]);
    logic [ADDR_W-1:0] unit_a;
    logic [OFF_W-1:0]  off;
    logic [ADDR_W:0]   range_end;
    flash_req_t        tail;
    res.delete();
    unit_a = {a.addr[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
    off    = a.addr[OFF_W-1:0];
    if (st.awaiting_fill) begin
      if (a.op != OP_FILL || a.addr != ADDR_W'(st.fill_cnt)) begin
        add_req(res, K_REJ, '0, '0, '0);
      end else begin
        st.bytes[st.fill_cnt[OFF_W-1:0]] = a.data;
        st.fill_cnt = st.fill_cnt + 1'b1;
        if (st.fill_cnt < UNIT_BYTES) begin
          add_req(res, K_ACK, '0, '0, '0);
        end else begin
          // unit complete: the held write lands on top of the fill
          st.awaiting_fill = 1'b0;
          st.fill_cnt = '0;
          st.bytes[st.held_off] = st.held_byte;
          st.valid = 1'b1;
          if (st.held_off == OFF_W'(UNIT_BYTES - 1)) commit_unit(st, res);
          else add_req(res, K_ACK, '0, '0, '0);
        end
      end
    end else if (st.direct) begin
      if (a.op == OP_WRITE && unit_a == st.unit_base) begin
        add_req(res, K_PROG, a.addr, a.data, '0);
        if (off == OFF_W'(UNIT_BYTES - 1)) begin
          add_req(res, K_SYNC, '0, '0, '0);
          st.direct = 1'b0;
        end
      end else begin
        add_req(res, K_REJ, '0, '0, '0);
      end
    end else begin
      case (a.op)
        OP_READ: begin
          if (st.valid && a.addr >= st.unit_base &&
              {1'b0, a.addr} < {1'b0, st.unit_base} + UNIT_BYTES)
            add_req(res, K_HIT, a.addr, st.bytes[off], '0);
          else
            add_req(res, K_READ, a.addr, '0, 1);
        end
        OP_WRITE: begin
          if (unit_a != st.unit_base) flush_unit(st, res);
          if (off == '0 && a.len >= UNIT_BYTES) begin
            st.valid = 1'b0;
            st.unit_base = unit_a;
            st.direct = 1'b1;
            add_req(res, K_PROG, a.addr, a.data, '0);
          end else if (!st.valid) begin
            st.unit_base = unit_a;
            st.awaiting_fill = 1'b1;
            st.fill_cnt = '0;
            st.held_off = off;
            st.held_byte = a.data;
            add_req(res, K_READ, unit_a, '0, UNIT_BYTES);
          end else begin
            st.bytes[off] = a.data;
            if (off == OFF_W'(UNIT_BYTES - 1)) commit_unit(st, res);
            else add_req(res, K_ACK, '0, '0, '0);
          end
        end
        OP_ERASE, OP_TRIM: begin
          // range end is inclusive and does not wrap
          range_end = {1'b0, a.addr} + {1'b0, a.len};
          if (st.valid && st.unit_base >= a.addr && {1'b0, st.unit_base} <= range_end)
            st.valid = 1'b0;
          add_req(res, (a.op == OP_ERASE) ? K_ERASE : K_TRIM, a.addr, '0, a.len);
        end
        OP_SYNC: commit_unit(st, res);
        default: add_req(res, K_REJ, '0, '0, '0);
      endcase
    end
    tail = res.pop_back();
    tail.last = 1'b1;
    res.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------
  task automatic plan(input logic [CODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                      input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len);
    access_t    a;
    flash_req_t outs[$];
    a = '{op, addr, data, len, drain_next, 2'd0};
    drain_next = 1'b0;
    access_plan.push_back(a);
    combine_access(plan_buf, a, outs);
    if (!(outs.size() == 1 && outs[0].kind == K_REJ)) planned_live++;
  endtask

  function automatic logic [LEN_W-1:0] any_len();
    case ($urandom_range(5))
      0:       return '0;
      1:       return LEN_W'($urandom_range(1, UNIT_BYTES - 1));
      2:       return UNIT_BYTES;
      3:       return '1;
      4:       return LEN_W'($urandom_range(UNIT_BYTES + 1, 200));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_unit();
    case ($urandom_range(4))
      0, 1:    return plan_buf.unit_base;
      2:       return '0;
      3:       return {{(ADDR_W - OFF_W){1'b1}}, {OFF_W{1'b0}}};
      default: return $urandom & ~ADDR_W'(UNIT_BYTES - 1);
    endcase
  endfunction

  initial begin
    logic [ADDR_W-1:0] u;
    logic [OFF_W-1:0]  off;
    logic [CODE_W-1:0] op;

    // directed: extremes, rejects, range commands, direct write, zero-length write
    plan(OP_READ, '0, '0, '0);
    plan(OP_READ, '1, '1, '1);
    plan(OP_FILL, '0, 8'hFF, '0);                 // fill with nothing outstanding
    plan(OP_SPARE6, '1, '1, '1);
    plan(OP_SPARE7, '0, '0, '0);
    plan(OP_SYNC, '0, '0, '0);                    // nothing cached, sync only
    plan(OP_ERASE, '0, '0, '0);
    plan(OP_ERASE, '1, '0, '1);
    plan(OP_TRIM, 32'h1234_5678, 8'h5A, 32'h100);
    drain_next = 1'b1;
    plan(OP_WRITE, 32'hFFFF_FFE0, 8'hA5, '1);     // starts a direct unit write
    plan(OP_READ, 32'hFFFF_FFE1, '0, '0);         // rejected while direct
    plan(OP_WRITE, 32'h0000_0040, 8'h11, 1);      // other unit, rejected
    plan(OP_WRITE, 32'hFFFF_FFE5, 8'h00, 27);
    plan(OP_WRITE, 32'hFFFF_FFFF, 8'hFF, 1);      // last byte: program + sync
    plan(OP_WRITE, 32'h0000_0040, 8'h3C, 0);      // zero length acts as partial
    plan(OP_READ, 32'h0000_0040, '0, '0);         // rejected during fill
    plan(OP_FILL, 1, 8'h77, '0);                  // out-of-order fill, rejected
    plan(OP_SYNC, '0, '0, '0);                    // rejected during fill

    // random: mostly well-formed sequences steered by the planned cache state
    planned_live = 0;
    drain_next = 1'b1;
    while (planned_live < RAND_ACCESSES) begin
      if (plan_buf.awaiting_fill) begin
        if ($urandom_range(11) == 0) begin
          op = CODE_W'($urandom_range(7));
          plan(op, (op == OP_FILL) ? ADDR_W'(plan_buf.fill_cnt) + 1 : $urandom,
               DATA_W'($urandom_range(255)), $urandom);
        end else begin
          plan(OP_FILL, ADDR_W'(plan_buf.fill_cnt), DATA_W'($urandom_range(255)), $urandom);
        end
      end else if (plan_buf.direct) begin
        if ($urandom_range(9) == 0)
          plan(OP_WRITE, plan_buf.unit_base + UNIT_BYTES, DATA_W'($urandom_range(255)), 1);
        else begin
          off = ($urandom_range(3) == 0) ? OFF_W'(UNIT_BYTES - 1)
                                         : OFF_W'($urandom_range(UNIT_BYTES - 2));
          plan(OP_WRITE, plan_buf.unit_base | ADDR_W'(off), DATA_W'($urandom_range(255)),
               any_len());
        end
      end else begin
        if ($urandom_range(14) == 0) drain_next = 1'b1;
        case ($urandom_range(9))
          0, 1: begin
            u = pick_unit();
            off = OFF_W'($urandom_range(UNIT_BYTES - 1));
            plan(OP_WRITE, u | ADDR_W'(off), DATA_W'($urandom_range(255)),
                 (off == '0) ? LEN_W'($urandom_range(UNIT_BYTES - 1)) : any_len());
          end
          2: plan(OP_WRITE, pick_unit(), DATA_W'($urandom_range(255)),
                  LEN_W'($urandom_range(UNIT_BYTES, 32'hFFFF_FFFF)));
          3, 4: plan(OP_READ, $urandom_range(1) ? plan_buf.unit_base |
                     ADDR_W'($urandom_range(UNIT_BYTES - 1)) : $urandom,
                     DATA_W'($urandom_range(255)), $urandom);
          5: begin
            off = ($urandom_range(2) == 0) ? OFF_W'(UNIT_BYTES - 1)
                                           : OFF_W'($urandom_range(UNIT_BYTES - 1));
            plan(OP_WRITE, plan_buf.unit_base | ADDR_W'(off), DATA_W'($urandom_range(255)),
                 LEN_W'($urandom_range(UNIT_BYTES - 1)));
          end
          6: begin
            op = $urandom_range(1) ? OP_ERASE : OP_TRIM;
            case ($urandom_range(2))
              0: plan(op, plan_buf.unit_base - ADDR_W'($urandom_range(64)),
                      DATA_W'($urandom_range(255)), LEN_W'($urandom_range(128)));
              1: plan(op, plan_buf.unit_base, '0, '0);
              default: plan(op, $urandom, DATA_W'($urandom_range(255)), $urandom);
            endcase
          end
          7: plan(OP_SYNC, $urandom, DATA_W'($urandom_range(255)), $urandom);
          default: plan(CODE_W'($urandom_range(7)), $urandom, DATA_W'($urandom_range(255)),
                        $urandom);
        endcase
      end
    end

    foreach (access_plan[i]) access_plan[i].phase = 2'((i * 3) / access_plan.size());
  end

  // ---------------------------------------------------------------------
  // Request driver: predicts on acceptance, then presents the next access
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    flash_req_t outs[$];
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        combine_access(shadow_buf, cur_access, outs);
        foreach (outs[i]) owed_reqs.push_back(outs[i]);
        holding = 1'b0;
      end
      if (!holding && access_plan.size() != 0) begin
        if (!(access_plan[0].drain && owed_reqs.size() != 0) &&
            $urandom_range(99) >= SEND_IDLE_PCT[access_plan[0].phase]) begin
          cur_access = access_plan.pop_front();
          holding = 1'b1;
          drive_phase <= cur_access.phase;
        end
      end
      s_axis_tvalid <= holding;
      s_axis_tdata  <= {cur_access.len, cur_access.data, cur_access.addr};
      s_axis_tuser  <= cur_access.op;
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor with random back-pressure
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    flash_req_t got;
    flash_req_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind_e'(m_axis_tuser), m_axis_tdata[ADDR_W-1:0],
                m_axis_tdata[ADDR_W+DATA_W-1:ADDR_W], m_axis_tdata[TDATA_W-1:ADDR_W+DATA_W],
                m_axis_tlast};
        if (owed_reqs.size() == 0) begin
          errors++;
          $display("%0t: unexpected request kind=%0d addr=%h data=%h len=%h last=%b",
                   $time, got.kind, got.addr, got.data, got.len, got.last);
        end else begin
          want = owed_reqs.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch exp k=%0d a=%h d=%h l=%h t=%b got k=%0d a=%h d=%h l=%h t=%b",
                     $time, want.kind, want.addr, want.data, want.len, want.last,
                     got.kind, got.addr, got.data, got.len, got.last);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= RECV_STALL_PCT[drive_phase]);
    end
  end

  // ---------------------------------------------------------------------
  // End of run
  // ---------------------------------------------------------------------
  initial begin
    wait (rst_ni);
    while (access_plan.size() != 0 || holding || owed_reqs.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && owed_reqs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/fwcb_pkg.sv
rtl/flash_write_combining_buffer.sv
dv/flash_write_combining_buffer_tb.sv
